>>> hdl/heightmap_normal_calculation_core_macros.svh
// Assertion macros shared by the heightmap normal core
`ifndef HEIGHTMAP_NORMAL_CALCULATION_CORE_MACROS_SVH
`define HEIGHTMAP_NORMAL_CALCULATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HNC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hnc assertion failed");
`define HNC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hnc assertion failed");
`else
`define HNC_ASSERT_IMP(lbl, ante, cons)
`define HNC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/hnc_pkg.sv
// Types, states and triangle table of the heightmap normal core
package hnc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CTR,
        ST_IA,
        ST_RA,
        ST_RB,
        ST_TRI,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic {
        UOP_SQRT,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_ctl;

    typedef struct packed {
        logic signed [1:0] x1;
        logic signed [1:0] z1;
        logic signed [1:0] x2;
        logic signed [1:0] z2;
    } t_tri_ofs;

    localparam int TRI_NUM   = 20;
    localparam int SQRT_BITS = 32;
    localparam int DIV_BITS  = 24;
    localparam logic [15:0] NRM_ONE = 16'd16384;

    localparam logic [4:0] TRI_CORNER_00 = 5'd0;
    localparam logic [4:0] TRI_CORNER_LL = 5'd1;
    localparam logic [4:0] TRI_CORNER_0L = 5'd2;
    localparam logic [4:0] TRI_CORNER_L0 = 5'd3;
    localparam logic [4:0] TRI_ROW_FIRST = 5'd4;
    localparam logic [4:0] TRI_COL_FIRST = 5'd6;
    localparam logic [4:0] TRI_ROW_LAST  = 5'd8;
    localparam logic [4:0] TRI_COL_LAST  = 5'd10;
    localparam logic [4:0] TRI_INNER     = 5'd12;

    localparam t_tri_ofs TRI_TAB [TRI_NUM] = '{
        '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1}, '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0}, '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0}, '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{-2'sd1,  2'sd0, -2'sd1,  2'sd1}, '{-2'sd1,  2'sd1,  2'sd0,  2'sd1},
        '{ 2'sd0,  2'sd1,  2'sd1,  2'sd1}, '{ 2'sd1,  2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd1, -2'sd1}, '{ 2'sd1, -2'sd1,  2'sd0, -2'sd1},
        '{ 2'sd0, -2'sd1, -2'sd1, -2'sd1}, '{-2'sd1, -2'sd1, -2'sd1,  2'sd0}
    };

endpackage

>>> hdl/hnc_ram.sv
// Generic single-clock RAM with one write port and one registered read port
module hnc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/hnc_iter.sv
// Shared bit-serial unit: floor square root or long division, one bit per cycle
module hnc_iter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hnc_pkg::t_unit_ctl i_ctl,
    input  logic [63:0]        i_a,
    input  logic [33:0]        i_b,
    output logic [31:0]        o_res,
    output logic               o_done
);

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    hnc_pkg::t_unit_op r_op;
    logic [63:0]      r_a;
    logic [33:0]      r_b;
    logic [35:0]      r_rem;
    logic [31:0]      r_res;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    always_comb begin
        if (r_op == hnc_pkg::UOP_SQRT) begin
            rem_sh = {r_rem[33:0], r_a[63:62]};
            trial  = {2'b00, r_res, 2'b01};
        end else begin
            rem_sh = {r_rem[34:0], r_a[63]};
            trial  = {2'b00, r_b};
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_b   <= i_b;
            r_res <= '0;
            if (i_ctl.op == hnc_pkg::UOP_SQRT) begin
                r_cnt <= 5'(hnc_pkg::SQRT_BITS - 1);
                r_a   <= i_a;
                r_rem <= '0;
            end else begin
                // quotient bits come from the low part; the high part seeds the remainder
                r_cnt <= 5'(hnc_pkg::DIV_BITS - 1);
                r_a   <= i_a << (64 - hnc_pkg::DIV_BITS);
                r_rem <= i_a[59:hnc_pkg::DIV_BITS];
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            r_a   <= (r_op == hnc_pkg::UOP_SQRT) ? (r_a << 2) : (r_a << 1);
            r_rem <= take ? (rem_sh - trial) : rem_sh;
            r_res <= {r_res[30:0], take};
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

>>> hdl/heightmap_normal_calculation_core.sv
// Top level: height grid in RAM and a sequencer that builds averaged vertex normals
// A write is taken in the idle state; busy stays low and the next item may follow at once.
// A query visits 1, 2 or 8 triangles, normalizing each triangle normal, and then runs
// a final normalization of the summed normal; the shared square-root/divide unit
// retires one bit per cycle while busy.
// The result shows on o_valid for one cycle; reset (synchronous, low) returns to idle.
`include "heightmap_normal_calculation_core_macros.svh"
module heightmap_normal_calculation_core #(
    parameter int GRID_SIDE = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    input  logic signed [15:0] i_height,
    output logic               o_valid,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z
);

    localparam int XW = $clog2(GRID_SIDE);
    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);

    hnc_pkg::t_state n_state, r_state;

    logic [XW-1:0]         r_col, r_row;
    logic [4:0]            r_tri, r_tri_end;
    logic                  r_final;
    logic signed [15:0]    r_h0, r_ha, r_hb;
    logic signed [24:0]    r_v [3];
    logic signed [24:0]    r_sum [3];
    logic [1:0]            r_k;
    logic [49:0]           r_prod, r_acc;
    logic [31:0]           r_len;
    logic signed [15:0]    r_nrm_x, r_nrm_y, r_nrm_z;

    logic                  accept, in_grid;
    logic [XW-1:0]         in_col, in_row;
    logic [4:0]            sel_first, sel_end;
    logic [AW-1:0]         ctr_addr, nb_addr, raddr;
    logic [15:0]           rdata;
    logic                  ram_we;
    hnc_pkg::t_tri_ofs     ofs;
    logic [XW-1:0]         nx, nz;
    logic signed [24:0]    v_sel, v_mag;
    logic signed [16:0]    ay, by;
    logic signed [24:0]    n0, n1, n2;
    logic                  u_done;
    logic [31:0]           u_res;
    hnc_pkg::t_unit_ctl    u_ctl;
    logic [63:0]           u_a;
    logic [23:0]           q;
    logic signed [24:0]    q_signed;
    logic [15:0]           q_sat;
    logic signed [15:0]    q_out;

    function automatic logic signed [24:0] smul(input logic signed [16:0] v,
                                                input logic signed [1:0] s);
        logic signed [24:0] r;
        r = 25'(v);
        if (s == 2'sd1) begin
            return r;
        end else if (s == -2'sd1) begin
            return -r;
        end
        return '0;
    endfunction

    assign in_grid = (32'(i_col) < GRID_SIDE) && (32'(i_row) < GRID_SIDE);
    assign accept  = start && !busy;
    assign in_col  = XW'(i_col);
    assign in_row  = XW'(i_row);
    assign ctr_addr = AW'(in_row) * AW'(GRID_SIDE) + AW'(in_col);

    always_comb begin
        priority if (in_col == '0 && in_row == '0) begin
            sel_first = hnc_pkg::TRI_CORNER_00; sel_end = 5'd1;
        end else if (in_col == XW'(GRID_SIDE - 1) && in_row == XW'(GRID_SIDE - 1)) begin
            sel_first = hnc_pkg::TRI_CORNER_LL; sel_end = 5'd2;
        end else if (in_col == '0 && in_row == XW'(GRID_SIDE - 1)) begin
            sel_first = hnc_pkg::TRI_CORNER_0L; sel_end = 5'd3;
        end else if (in_col == XW'(GRID_SIDE - 1) && in_row == '0) begin
            sel_first = hnc_pkg::TRI_CORNER_L0; sel_end = 5'd4;
        end else if (in_row == '0) begin
            sel_first = hnc_pkg::TRI_ROW_FIRST; sel_end = 5'd6;
        end else if (in_col == '0) begin
            sel_first = hnc_pkg::TRI_COL_FIRST; sel_end = 5'd8;
        end else if (in_row == XW'(GRID_SIDE - 1)) begin
            sel_first = hnc_pkg::TRI_ROW_LAST; sel_end = 5'd10;
        end else if (in_col == XW'(GRID_SIDE - 1)) begin
            sel_first = hnc_pkg::TRI_COL_LAST; sel_end = 5'd12;
        end else begin
            sel_first = hnc_pkg::TRI_INNER; sel_end = 5'd20;
        end
    end

    // neighbor address: first corner while fetching A, second while fetching B
    always_comb begin
        ofs = hnc_pkg::TRI_TAB[r_tri];
        if (r_state == hnc_pkg::ST_RA) begin
            nx = r_col + XW'(ofs.x2);
            nz = r_row + XW'(ofs.z2);
        end else begin
            nx = r_col + XW'(ofs.x1);
            nz = r_row + XW'(ofs.z1);
        end
        nb_addr = AW'(nz) * AW'(GRID_SIDE) + AW'(nx);
    end

    always_comb begin
        ay = 17'(r_ha) - 17'(r_h0);
        by = 17'(r_hb) - 17'(r_h0);
        n0 = smul(ay, ofs.z2) - smul(by, ofs.z1);
        n1 = (smul(17'(ofs.x2), ofs.z1) - smul(17'(ofs.z2), ofs.x1)) <<< 8;
        n2 = smul(by, ofs.x1) - smul(ay, ofs.x2);
    end

    always_comb begin
        unique case (r_k)
            2'd0:    v_sel = r_v[0];
            2'd1:    v_sel = r_v[1];
            2'd2:    v_sel = r_v[2];
            default: v_sel = '0;
        endcase
        v_mag = (v_sel < 0) ? -v_sel : v_sel;
        u_a = '0;
        if (r_state == hnc_pkg::ST_SQRT_GO) begin
            u_a = r_final ? (64'(r_acc) << 14) : (64'(r_acc) << 24);
        end else begin
            u_a = (64'(unsigned'(v_mag)) << (r_final ? 22 : 33)) + 64'(r_len);
        end
        q        = (r_len == '0) ? '0 : u_res[23:0];
        q_signed = (v_sel < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
        q_sat    = (q > 24'(hnc_pkg::NRM_ONE)) ? hnc_pkg::NRM_ONE : q[15:0];
        q_out    = ((v_sel < 0) ^ (r_k == 2'd2)) ? -$signed(q_sat) : $signed(q_sat);
    end

    hnc_ram #(
        .WIDTH(16),
        .DEPTH(GRID_SIDE * GRID_SIDE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ctr_addr),
        .i_wdata (i_height),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hnc_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (u_ctl),
        .i_a     (u_a),
        .i_b     (34'({r_len, 1'b0})),
        .o_res   (u_res),
        .o_done  (u_done)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hnc_pkg::ST_IDLE:
                if (accept && i_action && in_grid) n_state = hnc_pkg::ST_CTR;
            hnc_pkg::ST_CTR:      n_state = hnc_pkg::ST_RA;
            hnc_pkg::ST_IA:       n_state = hnc_pkg::ST_RA;
            hnc_pkg::ST_RA:       n_state = hnc_pkg::ST_RB;
            hnc_pkg::ST_RB:       n_state = hnc_pkg::ST_TRI;
            hnc_pkg::ST_TRI:      n_state = hnc_pkg::ST_SQ;
            hnc_pkg::ST_SQ:
                if (r_k == 2'd3) n_state = hnc_pkg::ST_SQRT_GO;
            hnc_pkg::ST_SQRT_GO:  n_state = hnc_pkg::ST_SQRT_WAIT;
            hnc_pkg::ST_SQRT_WAIT:
                if (u_done) n_state = hnc_pkg::ST_DIV_GO;
            hnc_pkg::ST_DIV_GO:   n_state = hnc_pkg::ST_DIV_WAIT;
            hnc_pkg::ST_DIV_WAIT:
                if (u_done) begin
                    priority if (r_k != 2'd2) begin
                        n_state = hnc_pkg::ST_DIV_GO;
                    end else if (r_final) begin
                        n_state = hnc_pkg::ST_OUT;
                    end else if (r_tri + 5'd1 == r_tri_end) begin
                        n_state = hnc_pkg::ST_FIN;
                    end else begin
                        n_state = hnc_pkg::ST_IA;
                    end
                end
            hnc_pkg::ST_FIN:      n_state = hnc_pkg::ST_SQ;
            hnc_pkg::ST_OUT:      n_state = hnc_pkg::ST_IDLE;
            default:              n_state = hnc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy     = (r_state != hnc_pkg::ST_IDLE);
        o_valid  = (r_state == hnc_pkg::ST_OUT);
        ram_we   = (r_state == hnc_pkg::ST_IDLE) && accept && !i_action && in_grid;
        raddr    = (r_state == hnc_pkg::ST_IDLE) ? ctr_addr : nb_addr;
        u_ctl.start = (r_state == hnc_pkg::ST_SQRT_GO) || (r_state == hnc_pkg::ST_DIV_GO);
        u_ctl.op    = (r_state == hnc_pkg::ST_SQRT_GO) ? hnc_pkg::UOP_SQRT : hnc_pkg::UOP_DIV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hnc_pkg::ST_IDLE: begin
                r_col     <= in_col;
                r_row     <= in_row;
                r_tri     <= sel_first;
                r_tri_end <= sel_end;
                r_final   <= 1'b0;
                r_k       <= 2'd0;
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            end
            hnc_pkg::ST_CTR: r_h0 <= $signed(rdata);
            hnc_pkg::ST_RA:  r_ha <= $signed(rdata);
            hnc_pkg::ST_RB:  r_hb <= $signed(rdata);
            hnc_pkg::ST_TRI: begin
                r_v[0] <= n0;
                r_v[1] <= n1;
                r_v[2] <= n2;
                r_k    <= 2'd0;
            end
            hnc_pkg::ST_SQ: begin
                // square one component per beat into r_prod; r_acc adds the registered product
                r_prod <= {25'd0, v_mag} * {25'd0, v_mag};
                r_acc  <= (r_k == 2'd0) ? '0 : r_acc + r_prod;
                r_k    <= (r_k == 2'd3) ? 2'd0 : r_k + 2'd1;
            end
            hnc_pkg::ST_SQRT_WAIT:
                if (u_done) r_len <= u_res;
            hnc_pkg::ST_DIV_WAIT:
                if (u_done) begin
                    if (r_final) begin
                        unique case (r_k)
                            2'd0:    r_nrm_x <= q_out;
                            2'd1:    r_nrm_y <= q_out;
                            default: r_nrm_z <= q_out;
                        endcase
                    end else begin
                        unique case (r_k)
                            2'd0:    r_sum[0] <= r_sum[0] + q_signed;
                            2'd1:    r_sum[1] <= r_sum[1] + q_signed;
                            default: r_sum[2] <= r_sum[2] + q_signed;
                        endcase
                    end
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0;
                        if (!r_final) r_tri <= r_tri + 5'd1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
            hnc_pkg::ST_FIN: begin
                r_v[0]  <= r_sum[0];
                r_v[1]  <= r_sum[1];
                r_v[2]  <= r_sum[2];
                r_final <= 1'b1;
                r_k     <= 2'd0;
            end
            default: begin
            end
        endcase
    end

    assign o_normal_x = r_nrm_x;
    assign o_normal_y = r_nrm_y;
    assign o_normal_z = r_nrm_z;

    `HNC_ASSERT_NXT(a_valid_single, o_valid, !o_valid)
    `HNC_ASSERT_NXT(a_write_no_result, start && !busy && !i_action, !o_valid)
    `HNC_ASSERT_IMP(a_done_when_waiting, u_done, r_state == hnc_pkg::ST_SQRT_WAIT || r_state == hnc_pkg::ST_DIV_WAIT)
    `HNC_ASSERT_IMP(a_unit_range, o_valid, o_normal_y >= -16'sd16384 && o_normal_y <= 16'sd16384 && o_normal_x >= -16'sd16384 && o_normal_x <= 16'sd16384)

endmodule
